[rtl/core/sorted_timer_queue_top_assert.svh]
// assertion macros for the sorted timer queue
`ifndef SORTED_TIMER_QUEUE_TOP_ASSERT_SVH
`define SORTED_TIMER_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stq check failed");

// next-cycle implication, checked out of reset
`define STQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stq check failed");

`endif

[rtl/core/stq_pkg.sv]
// shared types and constants of the sorted timer queue
`default_nettype none

package stq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int HDL_W  = 8;
  localparam int TIME_W = 32;
  localparam int STAT_W = 3;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_ADJUST = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE         = 3'd0,
    ST_EXPIRED      = 3'd1,
    ST_FULL         = 3'd2,
    ST_NOT_FOUND    = 3'd3,
    ST_NONE_EXPIRED = 3'd4,
    ST_DUPLICATE    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_DECIDE,
    S_POS,
    S_TICK,
    S_EMIT
  } state_t;

  // write request to the entry store
  typedef struct packed {
    logic              insert;
    logic              remove;
    logic [IDX_W-1:0]  pos;
    logic [HDL_W-1:0]  handle;
    logic [TIME_W-1:0] expiry;
  } store_op_t;

  // operands of the shared compare unit
  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic [HDL_W-1:0]  ha;
    logic [HDL_W-1:0]  hb;
  } cmp_in_t;

  typedef struct packed {
    logic lt;
    logic heq;
  } cmp_out_t;

  function automatic logic [IDX_W-1:0] idx_of(input int i);
    return IDX_W'(i);
  endfunction

endpackage

`default_nettype wire

[rtl/core/stq_if.sv]
// valid/ready channels of the sorted timer queue
`default_nettype none

interface stq_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [stq_pkg::HDL_W-1:0]  timer_handle;
  logic [stq_pkg::TIME_W-1:0] expiry_time;
  logic [stq_pkg::TIME_W-1:0] current_time;

  modport source (output valid, output command, output timer_handle,
                  output expiry_time, output current_time, input ready);
  modport sink   (input valid, input command, input timer_handle,
                  input expiry_time, input current_time, output ready);
endinterface

interface stq_out_if;
  logic                       valid;
  logic                       ready;
  logic [stq_pkg::STAT_W-1:0] status;
  logic [stq_pkg::HDL_W-1:0]  result_handle;
  logic [stq_pkg::TIME_W-1:0] result_expiry;
  logic                       last;

  modport source (output valid, output status, output result_handle,
                  output result_expiry, output last, input ready);
  modport sink   (input valid, input status, input result_handle,
                  input result_expiry, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/sorted_timer_queue_top.sv]
// top level of the sorted timer queue: sequencer, result buffer and output register
// one command at a time: the next beat is taken the cycle after the last result is loaded
// the handle scan and the insert-place scan share one compare unit, one entry a cycle
// sync active-low reset empties the table (count zero) and idles the sequencer
`default_nettype none

module sorted_timer_queue_top (
  input  logic      clk,
  input  logic      rst_n,
  stq_in_if.sink    in_ch,
  stq_out_if.source out_ch
);

  `include "sorted_timer_queue_top_assert.svh"

  // sequencer state
  stq_pkg::state_t state_r, state_nxt;

  // latched command beat
  stq_pkg::cmd_t              cmd_r, cmd_nxt;
  logic [stq_pkg::HDL_W-1:0]  hdl_r, hdl_nxt;
  logic [stq_pkg::TIME_W-1:0] exp_r, exp_nxt;
  logic [stq_pkg::TIME_W-1:0] now_r, now_nxt;

  // scan position and find result
  logic [stq_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [stq_pkg::IDX_W-1:0]  fpos_r, fpos_nxt;
  logic                       found_r, found_nxt;

  // pending result (also holds the previous expired timer during tick)
  logic                       res_valid_r, res_valid_nxt;
  stq_pkg::status_t           res_status_r, res_status_nxt;
  logic [stq_pkg::HDL_W-1:0]  res_h_r, res_h_nxt;
  logic [stq_pkg::TIME_W-1:0] res_e_r, res_e_nxt;

  // output register
  logic                       out_valid_r;
  stq_pkg::status_t           out_status_r;
  logic [stq_pkg::HDL_W-1:0]  out_h_r;
  logic [stq_pkg::TIME_W-1:0] out_e_r;
  logic                       out_last_r;
  logic                       load_out;
  logic                       load_last;

  // store and compare unit
  stq_pkg::store_op_t         st_op;
  logic [stq_pkg::IDX_W-1:0]  rd_idx;
  logic [stq_pkg::HDL_W-1:0]  rd_handle;
  logic [stq_pkg::TIME_W-1:0] rd_expiry;
  logic [stq_pkg::CNT_W-1:0]  count;
  stq_pkg::cmp_in_t           cmp_req;
  stq_pkg::cmp_out_t          cmp_rsp;

  logic in_fire;
  logic out_free;
  logic at_end;
  logic expired;

  stq_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (st_op),
    .rd_idx    (rd_idx),
    .rd_handle (rd_handle),
    .rd_expiry (rd_expiry),
    .count     (count)
  );

  stq_cmp u_cmp (
    .req (cmp_req),
    .rsp (cmp_rsp)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign at_end   = (idx_r == count);

  // tick always looks at the head entry; scans walk idx
  assign rd_idx = (state_r == stq_pkg::S_TICK) ? '0 : idx_r[stq_pkg::IDX_W-1:0];

  // tick: a < b is now < expiry; scans: a < b is expiry < new time
  always_comb begin
    cmp_req.ha = rd_handle;
    cmp_req.hb = hdl_r;
    if (state_r == stq_pkg::S_TICK) begin
      cmp_req.a = now_r;
      cmp_req.b = rd_expiry;
    end else begin
      cmp_req.a = rd_expiry;
      cmp_req.b = exp_r;
    end
  end

  // head entry is at or before now
  assign expired = (count != '0) && !cmp_rsp.lt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stq_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = (stq_pkg::cmd_t'(in_ch.command) == stq_pkg::CMD_TICK) ?
                      stq_pkg::S_TICK : stq_pkg::S_FIND;
        end
      end
      stq_pkg::S_FIND: begin
        if (at_end || cmp_rsp.heq) begin
          state_nxt = stq_pkg::S_DECIDE;
        end
      end
      stq_pkg::S_DECIDE: begin
        unique case (cmd_r)
          stq_pkg::CMD_ADD: begin
            state_nxt = (found_r || count == stq_pkg::FULL_CNT) ?
                        stq_pkg::S_EMIT : stq_pkg::S_POS;
          end
          stq_pkg::CMD_ADJUST: state_nxt = found_r ? stq_pkg::S_POS : stq_pkg::S_EMIT;
          stq_pkg::CMD_DELETE: state_nxt = stq_pkg::S_EMIT;
          stq_pkg::CMD_TICK:   state_nxt = stq_pkg::S_EMIT;
          default:             state_nxt = stq_pkg::S_EMIT;
        endcase
      end
      stq_pkg::S_POS: begin
        if (at_end || !cmp_rsp.lt) begin
          state_nxt = stq_pkg::S_EMIT;
        end
      end
      stq_pkg::S_TICK: begin
        if (!expired) begin
          state_nxt = stq_pkg::S_EMIT;
        end
      end
      stq_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = stq_pkg::S_IDLE;
        end
      end
      default: state_nxt = stq_pkg::S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cmd_nxt        = cmd_r;
    hdl_nxt        = hdl_r;
    exp_nxt        = exp_r;
    now_nxt        = now_r;
    idx_nxt        = idx_r;
    fpos_nxt       = fpos_r;
    found_nxt      = found_r;
    res_valid_nxt  = res_valid_r;
    res_status_nxt = res_status_r;
    res_h_nxt      = res_h_r;
    res_e_nxt      = res_e_r;
    st_op          = '0;
    load_out       = 1'b0;
    load_last      = 1'b0;

    unique case (state_r)
      stq_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_nxt       = stq_pkg::cmd_t'(in_ch.command);
          hdl_nxt       = in_ch.timer_handle;
          exp_nxt       = in_ch.expiry_time;
          now_nxt       = in_ch.current_time;
          idx_nxt       = '0;
          found_nxt     = 1'b0;
          res_valid_nxt = 1'b0;
        end
      end
      stq_pkg::S_FIND: begin
        priority if (at_end) begin
          found_nxt = 1'b0;
        end else if (cmp_rsp.heq) begin
          found_nxt = 1'b1;
          fpos_nxt  = idx_r[stq_pkg::IDX_W-1:0];
          res_e_nxt = rd_expiry;
        end else begin
          idx_nxt = idx_r + stq_pkg::CNT_ONE;
        end
      end
      stq_pkg::S_DECIDE: begin
        res_h_nxt = hdl_r;
        idx_nxt   = '0;
        unique case (cmd_r)
          stq_pkg::CMD_ADD: begin
            priority if (found_r) begin
              res_status_nxt = stq_pkg::ST_DUPLICATE;
              res_e_nxt      = exp_r;
            end else if (count == stq_pkg::FULL_CNT) begin
              res_status_nxt = stq_pkg::ST_FULL;
              res_e_nxt      = exp_r;
            end else begin
              res_status_nxt = stq_pkg::ST_DONE;
            end
          end
          stq_pkg::CMD_ADJUST, stq_pkg::CMD_DELETE: begin
            if (!found_r) begin
              res_status_nxt = stq_pkg::ST_NOT_FOUND;
              res_e_nxt      = '0;
            end else begin
              // take the timer out; adjust puts it back during the place scan
              res_status_nxt = stq_pkg::ST_DONE;
              st_op.remove   = 1'b1;
              st_op.pos      = fpos_r;
            end
          end
          stq_pkg::CMD_TICK: begin
            res_status_nxt = stq_pkg::ST_NONE_EXPIRED;
          end
          default: begin
            res_status_nxt = stq_pkg::ST_NONE_EXPIRED;
          end
        endcase
      end
      stq_pkg::S_POS: begin
        // first entry whose expiry is not below the new time
        if (at_end || !cmp_rsp.lt) begin
          st_op.insert   = 1'b1;
          st_op.pos      = idx_r[stq_pkg::IDX_W-1:0];
          st_op.handle   = hdl_r;
          st_op.expiry   = exp_r;
          res_status_nxt = stq_pkg::ST_DONE;
          res_h_nxt      = hdl_r;
          res_e_nxt      = exp_r;
        end else begin
          idx_nxt = idx_r + stq_pkg::CNT_ONE;
        end
      end
      stq_pkg::S_TICK: begin
        if (expired) begin
          // the held timer is not last, another one follows
          if (!res_valid_r || out_free) begin
            load_out       = res_valid_r;
            res_valid_nxt  = 1'b1;
            res_status_nxt = stq_pkg::ST_EXPIRED;
            res_h_nxt      = rd_handle;
            res_e_nxt      = rd_expiry;
            st_op.remove   = 1'b1;
            st_op.pos      = '0;
          end
        end else if (!res_valid_r) begin
          res_status_nxt = stq_pkg::ST_NONE_EXPIRED;
          res_h_nxt      = '0;
          res_e_nxt      = '0;
        end
      end
      stq_pkg::S_EMIT: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_last = 1'b1;
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stq_pkg::S_IDLE;
      found_r     <= 1'b0;
      res_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      found_r     <= found_nxt;
      res_valid_r <= res_valid_nxt;
      idx_r       <= idx_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    hdl_r        <= hdl_nxt;
    exp_r        <= exp_nxt;
    now_r        <= now_nxt;
    fpos_r       <= fpos_nxt;
    res_status_r <= res_status_nxt;
    res_h_r      <= res_h_nxt;
    res_e_r      <= res_e_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_h_r      <= res_h_r;
      out_e_r      <= res_e_r;
      out_last_r   <= load_last;
    end
  end

  assign in_ch.ready          = (state_r == stq_pkg::S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.result_handle = out_h_r;
  assign out_ch.result_expiry = out_e_r;
  assign out_ch.last          = out_last_r;

  // checks
  `STQ_ASSERT_NOW(a_no_insert_full, st_op.insert, count < stq_pkg::FULL_CNT)
  `STQ_ASSERT_NOW(a_no_remove_empty, st_op.remove, count != '0)
  `STQ_ASSERT_NOW(a_no_overwrite, load_out, !out_valid_r || out_ch.ready)
  `STQ_ASSERT_NEXT(a_tick_entry,
    in_fire && stq_pkg::cmd_t'(in_ch.command) == stq_pkg::CMD_TICK,
    state_r == stq_pkg::S_TICK)

endmodule

`default_nettype wire

[rtl/core/stq_cmp.sv]
// shared compare unit: time magnitude and handle match
`default_nettype none

module stq_cmp (
  input  stq_pkg::cmp_in_t  req,
  output stq_pkg::cmp_out_t rsp
);

  assign rsp.lt  = (req.a < req.b);
  assign rsp.heq = (req.ha == req.hb);

endmodule

`default_nettype wire

[rtl/core/stq_store.sv]
// sorted entry store; insert and remove shift the entries in place
`default_nettype none

module stq_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  stq_pkg::store_op_t          op,
  input  logic [stq_pkg::IDX_W-1:0]   rd_idx,
  output logic [stq_pkg::HDL_W-1:0]   rd_handle,
  output logic [stq_pkg::TIME_W-1:0]  rd_expiry,
  output logic [stq_pkg::CNT_W-1:0]   count
);

  logic [stq_pkg::HDL_W-1:0]  handles_r  [stq_pkg::DEPTH];
  logic [stq_pkg::TIME_W-1:0] expiries_r [stq_pkg::DEPTH];
  logic [stq_pkg::CNT_W-1:0]  count_r;

  // each entry takes its upper or lower neighbor
  for (genvar g = 0; g < stq_pkg::DEPTH; g++) begin : g_entry
    logic ins_here;
    logic ins_shift;
    logic rem_shift;

    assign ins_here = op.insert && (stq_pkg::idx_of(g) == op.pos);
    if (g > 0) begin : g_up
      assign ins_shift = op.insert && (stq_pkg::idx_of(g) > op.pos);
    end else begin : g_up0
      assign ins_shift = 1'b0;
    end
    if (g < stq_pkg::DEPTH - 1) begin : g_dn
      assign rem_shift = op.remove && (stq_pkg::idx_of(g) >= op.pos);
    end else begin : g_dn0
      assign rem_shift = 1'b0;
    end

    always_ff @(posedge clk) begin
      if (ins_here) begin
        handles_r[g]  <= op.handle;
        expiries_r[g] <= op.expiry;
      end else if (ins_shift) begin
        handles_r[g]  <= handles_r[(g > 0) ? g - 1 : 0];
        expiries_r[g] <= expiries_r[(g > 0) ? g - 1 : 0];
      end else if (rem_shift) begin
        handles_r[g]  <= handles_r[(g < stq_pkg::DEPTH - 1) ? g + 1 : g];
        expiries_r[g] <= expiries_r[(g < stq_pkg::DEPTH - 1) ? g + 1 : g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (op.insert) begin
      count_r <= count_r + stq_pkg::CNT_ONE;
    end else if (op.remove) begin
      count_r <= count_r - stq_pkg::CNT_ONE;
    end
  end

  assign rd_handle = handles_r[rd_idx];
  assign rd_expiry = expiries_r[rd_idx];
  assign count     = count_r;

endmodule

`default_nettype wire
